// ===== hdl/adv_structure_parser_unit_defines.svh =====
`ifndef ADV_STRUCTURE_PARSER_UNIT_DEFINES_SVH
`define ADV_STRUCTURE_PARSER_UNIT_DEFINES_SVH

// Assertion helpers; each expects clk_i and rst_ni in scope.

// Condition that must hold at every clock edge out of reset.
`define ASP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/asp_pkg.sv =====
`default_nettype none

package asp_pkg;

  localparam int unsigned MaxUuidsDefault = 8;
  localparam int unsigned CountWidth      = 4;
  localparam int unsigned UuidWidth       = 16;

  // Structure type codes handled by the parser.
  localparam logic [7:0] TypeUuid16Partial  = 8'h02;
  localparam logic [7:0] TypeUuid16Complete = 8'h03;
  localparam logic [7:0] TypeServiceData16  = 8'h16;
  localparam logic [7:0] TypeAppearance     = 8'h19;
  localparam logic [7:0] TypeManufacturer   = 8'hFF;

  // Result queue depth; must be a power of two and at least two.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic {
    KindUuid    = 1'b0,
    KindSummary = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e           kind;
    logic [UuidWidth-1:0]   service_uuid;
    logic [15:0]            appearance_value;
    logic [15:0]            company_id;
    logic [CountWidth-1:0]  uuid_count;
    logic                   parse_stopped;
    logic                   end_of_report;
  } result_t;

  // Up to two results per byte: a UUID first, then the summary.
  typedef struct packed {
    logic    uuid_vld;
    logic    sum_vld;
    result_t uuid_res;
    result_t sum_res;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/adv_structure_parser_unit.sv =====
// Channel | Direction | Signals                                   | Transfer when
// --------+-----------+-------------------------------------------+---------------------------
// input   | in        | adv_byte_i, report_length_i               | in_valid_i & in_ready_o
// result  | out       | result_kind_o .. end_of_report_o          | out_valid_o & out_ready_i
//
// A byte is parsed in the cycle of its transfer; its results are registered
// into a four-entry result queue and presented at the output from there.
// One byte per cycle is sustained while the output side keeps up; a byte
// that yields both a UUID and the summary leaves its second result in the
// queue, which absorbs it, so the input does not stall in that case.
// The input is ready whenever the queue has room for two results, so input
// transfers continue while a finished result waits at the output.
// Reset is asynchronous and active low; it clears the parser state and the
// queue, and no clearing pass is needed afterwards.

`default_nettype none

module adv_structure_parser_unit #(
  parameter int unsigned MaxUuids = asp_pkg::MaxUuidsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  adv_byte_i,
  input  wire logic [7:0]  report_length_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [15:0]      service_uuid_o,
  output logic [15:0]      appearance_value_o,
  output logic [15:0]      company_id_o,
  output logic [3:0]       uuid_count_o,
  output logic             parse_stopped_o,
  output logic             end_of_report_o
);

  logic             accept;
  asp_pkg::push_t   push;
  asp_pkg::result_t head;

  // A byte transfer happens only when the queue can take both possible
  // results of that byte, so nothing is ever dropped.
  assign accept = in_valid_i && in_ready_o;

  // The parser holds the structure walk state and decides, for each
  // transferred byte, whether a UUID and/or the summary is produced.
  asp_parser #(
    .MaxUuids (MaxUuids)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .adv_byte_i      (adv_byte_i),
    .report_length_i (report_length_i),
    .push_o          (push)
  );

  // The result queue keeps results in order and decouples the two sides.
  asp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign result_kind_o      = head.kind;
  assign service_uuid_o     = head.service_uuid;
  assign appearance_value_o = head.appearance_value;
  assign company_id_o       = head.company_id;
  assign uuid_count_o       = head.uuid_count;
  assign parse_stopped_o    = head.parse_stopped;
  assign end_of_report_o    = head.end_of_report;

endmodule

`default_nettype wire

// ===== hdl/asp_parser.sv =====
`default_nettype none

module asp_parser #(
  parameter int unsigned MaxUuids = asp_pkg::MaxUuidsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   adv_byte_i,
  input  wire logic [7:0]   report_length_i,
  output asp_pkg::push_t    push_o
);

  localparam logic [asp_pkg::CountWidth-1:0] UuidCap =
    (MaxUuids > 15) ? 4'd15 : MaxUuids[asp_pkg::CountWidth-1:0];

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  didx_q, didx_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] app_q, app_d;
  logic [15:0] comp_q, comp_d;
  logic [asp_pkg::CountWidth-1:0] cnt_q, cnt_d;
  logic        stop_q, stop_d;

  logic [7:0]  len_eff;
  logic        last_byte;
  logic        uuid_hit;

  assign len_eff   = (report_length_i == 8'd0) ? 8'd1 : report_length_i;
  assign last_byte = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_eff};

  always_comb begin
    pos_d    = pos_q;
    rem_d    = rem_q;
    type_d   = type_q;
    didx_d   = didx_q;
    hold_d   = hold_q;
    app_d    = app_q;
    comp_d   = comp_q;
    cnt_d    = cnt_q;
    stop_d   = stop_q;
    uuid_hit = 1'b0;
    push_o   = '0;

    if (accept_i) begin
      if (!stop_q) begin
        if (rem_q == 8'd0) begin
          if ((adv_byte_i == 8'd0) ||
              (({1'b0, pos_q} + {1'b0, adv_byte_i}) >= {1'b0, len_eff})) begin
            stop_d = 1'b1;
          end else begin
            rem_d  = adv_byte_i;
            didx_d = 8'd0;
          end
        end else begin
          if (didx_q == 8'd0) begin
            type_d = adv_byte_i;
          end else if (type_q inside {asp_pkg::TypeAppearance,
                                      asp_pkg::TypeManufacturer}) begin
            if (didx_q == 8'd1) begin
              hold_d = adv_byte_i;
            end else if (didx_q == 8'd2) begin
              if (type_q == asp_pkg::TypeAppearance) begin
                app_d = {adv_byte_i, hold_q};
              end else begin
                comp_d = {adv_byte_i, hold_q};
              end
            end
          end else if (type_q inside {asp_pkg::TypeUuid16Partial,
                                      asp_pkg::TypeUuid16Complete}) begin
            // Odd body index holds the low byte of a pair.
            if (didx_q[0]) begin
              hold_d = adv_byte_i;
            end else if (cnt_q < UuidCap) begin
              uuid_hit = 1'b1;
            end
          end else if (type_q == asp_pkg::TypeServiceData16) begin
            if (didx_q == 8'd1) begin
              hold_d = adv_byte_i;
            end else if ((didx_q == 8'd2) && (cnt_q < UuidCap)) begin
              uuid_hit = 1'b1;
            end
          end
          if (didx_q != 8'hFF) begin
            didx_d = didx_q + 8'd1;
          end
          rem_d = rem_q - 8'd1;
        end
      end

      if (uuid_hit) begin
        cnt_d = cnt_q + 4'd1;
        push_o.uuid_vld                  = 1'b1;
        push_o.uuid_res.kind             = asp_pkg::KindUuid;
        push_o.uuid_res.service_uuid     = {adv_byte_i, hold_q};
        push_o.uuid_res.appearance_value = app_q;
        push_o.uuid_res.company_id       = comp_q;
        push_o.uuid_res.uuid_count       = cnt_q + 4'd1;
        push_o.uuid_res.parse_stopped    = stop_q;
        push_o.uuid_res.end_of_report    = 1'b0;
      end

      if (last_byte) begin
        push_o.sum_vld                  = 1'b1;
        push_o.sum_res.kind             = asp_pkg::KindSummary;
        push_o.sum_res.service_uuid     = '0;
        push_o.sum_res.appearance_value = app_d;
        push_o.sum_res.company_id       = comp_d;
        push_o.sum_res.uuid_count       = cnt_d;
        push_o.sum_res.parse_stopped    = stop_d;
        push_o.sum_res.end_of_report    = 1'b1;
        pos_d  = '0;
        rem_d  = '0;
        type_d = '0;
        didx_d = '0;
        hold_d = '0;
        app_d  = '0;
        comp_d = '0;
        cnt_d  = '0;
        stop_d = 1'b0;
      end else begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      rem_q  <= '0;
      type_q <= '0;
      didx_q <= '0;
      hold_q <= '0;
      app_q  <= '0;
      comp_q <= '0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      rem_q  <= rem_d;
      type_q <= type_d;
      didx_q <= didx_d;
      hold_q <= hold_d;
      app_q  <= app_d;
      comp_q <= comp_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/asp_result_fifo.sv =====
`default_nettype none

module asp_result_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire asp_pkg::push_t push_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output asp_pkg::result_t   head_o
);

  `include "adv_structure_parser_unit_defines.svh"

  localparam int unsigned PtrW = asp_pkg::FifoPtrW;
  localparam int unsigned CntW = asp_pkg::FifoPtrW + 1;
  localparam logic [CntW-1:0] Depth = CntW'(asp_pkg::FifoDepth);

  asp_pkg::result_t mem_q [asp_pkg::FifoDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      push_n;
  logic            pop;
  asp_pkg::result_t entry0;

  assign push_n = {1'b0, push_i.uuid_vld} + {1'b0, push_i.sum_vld};
  assign entry0 = push_i.uuid_vld ? push_i.uuid_res : push_i.sum_res;

  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for the worst case of two results from one byte.
  assign space_o     = (count_q <= (Depth - CntW'(2)));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d = pop ? (rd_ptr_q + PtrW'(1)) : rd_ptr_q;
    count_d  = count_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= entry0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.sum_res;
    end
  end

  `ASP_ASSERT_ALWAYS(a_count_bound, count_q <= Depth, "result queue occupancy out of range")
  `ASP_ASSERT_IMPLIES(a_no_overflow, push_n != 2'd0, (count_q + CntW'(push_n)) <= (Depth + CntW'(pop)), "result queue overflow")
  `ASP_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i && (push_n == 2'd0), $stable(count_q) && $stable(rd_ptr_q), "stalled queue changed occupancy")

endmodule

`default_nettype wire
